FILE: sv/signed_int_to_decimal_ascii_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SIDA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SIDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sida_pkg.sv
`default_nettype none

package sida_pkg;

    localparam int VALUE_BITS = 32;
    // Decimal digits needed for 2^VALUE_BITS - 1 (1233/4096 ~ log10(2)).
    localparam int DIGITS     = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS   = 4 * DIGITS;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);
    localparam int DIG_BITS   = $clog2(DIGITS);
    localparam int CHAR_BITS  = 7;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_BITS-1:0] MINUS_CODE = 7'd45;
    localparam logic [CHAR_BITS-1:0] ASCII_NINE = 7'd57;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_TRIM = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

`default_nettype wire

FILE: sv/signed_int_to_decimal_ascii_unit.sv
`default_nettype none

// Signed integer to decimal ASCII text. One item on the input channel is a
// two's complement integer of VALUE_BITS bits; the output channel then carries
// its decimal text one character per item, most significant first: '-' for a
// negative value, then the digits of the magnitude without leading zeros
// (zero prints as a single '0'). o_last marks the final character; no NUL is
// sent. The most negative value prints correctly since the magnitude is held
// unsigned. At 32 bits, after accept the unit runs bit-serial shift-and-add-3
// (one magnitude bit per cycle into a 10-digit BCD shift register), then trims
// leading zero digits one at a time (up to 9) until the first digit to print
// is found, then sends the characters (1 to 11) in turn, holding while the
// output side stalls. Dropped and printed digits always add up to ten. The
// input stall stays high from accept until the last character is loaded into
// the output register; the next item may then be taken while that last
// character still waits.
module signed_int_to_decimal_ascii_unit (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    input  wire signed [sida_pkg::VALUE_BITS-1:0] i_value,
    output logic                                  o_stall,
    output logic                                  o_valid,
    output logic [sida_pkg::CHAR_BITS-1:0]        o_char_code,
    output logic                                  o_last,
    input  wire                                   i_stall
);
    import sida_pkg::*;

    // Control state
    t_state                r_state, n_state;
    logic                  r_ovalid, n_ovalid;
    // Datapath
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [BCD_BITS-1:0]   r_bcd, n_bcd;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [DIG_BITS-1:0]   r_dig, n_dig;
    logic                  r_neg, n_neg;
    logic [CHAR_BITS-1:0]  r_char, n_char;
    logic                  r_last, n_last;

    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_abs;
    logic [BCD_BITS-1:0]   w_adj;
    logic [3:0]            w_top;
    logic                  w_accept;
    logic                  w_slot;

    assign w_raw    = i_value;
    // Unsigned magnitude: the most negative value maps to 2^(VALUE_BITS-1).
    assign w_abs    = w_raw[VALUE_BITS-1]
                    ? (~w_raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : w_raw;
    assign w_accept = i_valid && !o_stall;
    // Output register can take a character this cycle.
    assign w_slot   = !r_ovalid || !i_stall;
    assign w_top    = r_bcd[BCD_BITS-1 -: 4];

    // Add 3 to every BCD digit of 5 or more before the shift.
    always_comb begin
        w_adj = r_bcd;
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        n_mag    = r_mag;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_dig    = r_dig;
        n_neg    = r_neg;
        n_char   = r_char;
        n_last   = r_last;

        // Drop the character once the consumer takes it.
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mag   = w_abs;
                    n_neg   = w_raw[VALUE_BITS-1];
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                // Shift one magnitude bit into the BCD register.
                n_bcd = {w_adj[BCD_BITS-2:0], r_mag[VALUE_BITS-1]};
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(VALUE_BITS - 1)) begin
                    n_dig   = DIG_BITS'(DIGITS - 1);
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                // Drop leading zero digits, keeping at least one.
                if (w_top == 4'd0 && r_dig != '0) begin
                    n_bcd = {r_bcd[BCD_BITS-5:0], 4'd0};
                    n_dig = r_dig - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    if (r_neg) begin
                        n_char = MINUS_CODE;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = ASCII_ZERO + {3'b000, w_top};
                        n_last = (r_dig == '0);
                        n_bcd  = {r_bcd[BCD_BITS-5:0], 4'd0};
                        n_dig  = r_dig - 1'b1;
                        if (r_dig == '0) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_dig  <= n_dig;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

`default_nettype wire

FILE: sv/sida_check.sv
`default_nettype none

`include "signed_int_to_decimal_ascii_unit_defines.svh"

module sida_check (
    input wire                                   i_clk,
    input wire                                   i_rst_n,
    input wire                                   i_valid,
    input wire signed [sida_pkg::VALUE_BITS-1:0] i_value,
    input wire                                   o_stall,
    input wire                                   o_valid,
    input wire [sida_pkg::CHAR_BITS-1:0]         o_char_code,
    input wire                                   o_last,
    input wire                                   i_stall
);
    import sida_pkg::*;

    // Hold a stalled character.
    `SIDA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_char_code) && $stable(o_last), "stalled item changed")

    // Only a minus sign or a decimal digit goes out.
    `SIDA_ASSERT_NOW(a_code, i_clk, i_rst_n, o_valid, (o_char_code == MINUS_CODE) || (o_char_code >= ASCII_ZERO && o_char_code <= ASCII_NINE), "bad character code")

    // A minus sign is never the final character.
    `SIDA_ASSERT_NOW(a_minus, i_clk, i_rst_n, o_valid && o_char_code == MINUS_CODE, !o_last, "minus sign flagged last")

    // An accepted item occupies the converter on the next cycle.
    `SIDA_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "input not stalled after accept")

endmodule

bind signed_int_to_decimal_ascii_unit sida_check u_sida_check (.*);

`default_nettype wire
